@@ rtl/core/read_strand_transform_assert.svh @@
// Assertion macros for the read strand transform block.
// Each macro expects clk_i and rst_ni in scope.
`ifndef READ_STRAND_TRANSFORM_ASSERT_SVH
`define READ_STRAND_TRANSFORM_ASSERT_SVH

`ifndef ASSERT_OFF
`define RST_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define RST_NEVER(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("forbidden condition seen");
`else
`define RST_ASSERT(name, prop)
`define RST_NEVER(name, prop)
`endif

`endif

@@ rtl/core/rst_pkg.sv @@
package rst_pkg;

  localparam int unsigned CfgW          = 7;
  localparam logic [6:0]  CfgLenReset   = 7'd64;
  localparam int unsigned BaseW         = 8;
  localparam int unsigned ModeW         = 2;

  typedef struct packed {
    logic             valid;
    logic [ModeW-1:0] mode;
    logic             last;
  } rst_beat_t;

endpackage

@@ rtl/core/read_strand_transform.sv @@
// Channel   | Ports                                      | Handshake
// ----------+--------------------------------------------+--------------------------
// base in   | base_in_i, strand_mode_i                   | start & !busy
// config    | cfg_read_length_i                          | cfg_we_i
// base out  | base_out_o, strand_code_o, read_end_o,     | out_valid_o, one cycle
//           | bad_base_o                                 |
//
// A read of N bases is loaded at one beat per cycle while start is high, into a
// 1-port-read buffer memory. The last base starts emission: busy is high while one
// entry is read per cycle; the read data and its control are registered, and then
// registered again at the output. The next load overlaps the last two results.
// Reset clears the fill count, held mode and strobes, sets length to 64; no sweep.
// The receiver cannot stall; a result is offered for exactly one cycle.
`include "read_strand_transform_assert.svh"

module read_strand_transform
  import rst_pkg::*;
#(
  parameter int unsigned MAX_READ = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [BaseW-1:0] base_in_i,
  input  logic [ModeW-1:0] strand_mode_i,
  input  logic             cfg_we_i,
  input  logic [CfgW-1:0]  cfg_read_length_i,
  output logic             out_valid_o,
  output logic [BaseW-1:0] base_out_o,
  output logic [ModeW-1:0] strand_code_o,
  output logic             read_end_o,
  output logic             bad_base_o
);

  localparam int unsigned AW = $clog2(MAX_READ);
  localparam int unsigned LW = $clog2(MAX_READ + 1);

  typedef enum logic [1:0] {
    S_LOAD = 2'b01,
    S_EMIT = 2'b10
  } state_e;

  state_e           state_q, state_d;
  logic [CfgW-1:0]  cfg_len_q;
  logic [LW-1:0]    fill_q, fill_d;
  logic [ModeW-1:0] mode_q, mode_d;
  logic [AW-1:0]    k_q, k_d;
  rst_beat_t        s1_q, s1_d;

  logic [BaseW-1:0] mem_q [MAX_READ];
  logic [BaseW-1:0] rd_data_q;

  logic [CfgW-1:0]  len_clip;
  logic [LW-1:0]    len;
  logic [LW-1:0]    fill_inc;
  logic             accept;
  logic             emit_last;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;

  always_comb begin
    if (cfg_len_q == '0) begin
      len_clip = CfgW'(1);
    end else if (cfg_len_q > CfgW'(MAX_READ)) begin
      len_clip = CfgW'(MAX_READ);
    end else begin
      len_clip = cfg_len_q;
    end
  end

  assign len       = len_clip[LW-1:0];
  assign accept    = start && !busy;
  assign fill_inc  = fill_q + LW'(1);
  assign emit_last = (LW'(k_q) == (len - LW'(1)));
  assign rd_en     = (state_q == S_EMIT);
  assign rd_addr   = mode_q[0] ? AW'(len - LW'(1) - LW'(k_q)) : k_q;

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    mode_d  = mode_q;
    k_d     = k_q;
    s1_d    = '0;
    unique case (state_q)
      S_LOAD: begin
        if (accept) begin
          if (fill_q == '0) begin
            mode_d = strand_mode_i;
          end
          if (fill_inc >= len) begin
            fill_d  = '0;
            k_d     = '0;
            state_d = S_EMIT;
          end else begin
            fill_d = fill_inc;
          end
        end
      end
      S_EMIT: begin
        s1_d.valid = 1'b1;
        s1_d.mode  = mode_q;
        s1_d.last  = emit_last;
        k_d        = k_q + AW'(1);
        if (emit_last) begin
          state_d = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      cfg_len_q <= CfgLenReset;
      fill_q    <= '0;
      mode_q    <= '0;
      k_q       <= '0;
      s1_q      <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      mode_q  <= mode_d;
      k_q     <= k_d;
      s1_q    <= s1_d;
      if (cfg_we_i) begin
        cfg_len_q <= cfg_read_length_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem_q[fill_q[AW-1:0]] <= base_in_i;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign busy = (state_q == S_EMIT);

  rst_complement u_complement (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (s1_q),
    .data_i       (rd_data_q),
    .out_valid_o  (out_valid_o),
    .base_out_o   (base_out_o),
    .strand_code_o(strand_code_o),
    .read_end_o   (read_end_o),
    .bad_base_o   (bad_base_o)
  );

  `RST_ASSERT(a_fill_range, fill_q < LW'(MAX_READ))
  `RST_ASSERT(a_addr_range, (state_q == S_EMIT) |-> (LW'(rd_addr) < len))
  `RST_ASSERT(a_stage_from_emit, s1_q.valid |-> $past(state_q == S_EMIT))
  `RST_ASSERT(a_read_end_after_busy, $fell(busy) |-> ##1 (out_valid_o && read_end_o))
  `RST_NEVER(a_accept_in_emit, (state_q == S_EMIT) && accept)

endmodule

@@ rtl/core/rst_complement.sv @@
`include "read_strand_transform_assert.svh"

module rst_complement
  import rst_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rst_beat_t        ctl_i,
  input  logic [BaseW-1:0] data_i,
  output logic             out_valid_o,
  output logic [BaseW-1:0] base_out_o,
  output logic [ModeW-1:0] strand_code_o,
  output logic             read_end_o,
  output logic             bad_base_o
);

  localparam logic [7:0] ChUpA = 8'h41;
  localparam logic [7:0] ChLoA = 8'h61;
  localparam logic [7:0] ChUpC = 8'h43;
  localparam logic [7:0] ChLoC = 8'h63;
  localparam logic [7:0] ChUpG = 8'h47;
  localparam logic [7:0] ChLoG = 8'h67;
  localparam logic [7:0] ChUpT = 8'h54;
  localparam logic [7:0] ChLoT = 8'h74;
  localparam logic [7:0] ChUpN = 8'h4E;
  localparam logic [7:0] ChLoN = 8'h6E;

  logic             valid_q;
  logic [BaseW-1:0] base_q, base_d;
  logic [ModeW-1:0] mode_q;
  logic             last_q;
  logic             bad_q, bad_d;
  logic [BaseW-1:0] comp_base;
  logic             comp_bad;

  always_comb begin
    comp_bad = 1'b0;
    case (data_i) inside
      ChUpA, ChLoA: comp_base = ChUpT;
      ChUpC, ChLoC: comp_base = ChUpG;
      ChUpG, ChLoG: comp_base = ChUpC;
      ChUpT, ChLoT: comp_base = ChUpA;
      ChUpN, ChLoN: comp_base = ChUpN;
      default: begin
        comp_base = ChUpN;
        comp_bad  = 1'b1;
      end
    endcase
  end

  always_comb begin
    if (ctl_i.mode[1]) begin
      base_d = comp_base;
      bad_d  = comp_bad;
    end else begin
      base_d = data_i;
      bad_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      base_q <= base_d;
      bad_q  <= bad_d;
      mode_q <= ctl_i.mode;
      last_q <= ctl_i.last;
    end
  end

  assign out_valid_o   = valid_q;
  assign base_out_o    = base_q;
  assign strand_code_o = mode_q;
  assign read_end_o    = last_q;
  assign bad_base_o    = bad_q;

  `RST_ASSERT(a_bad_only_complement, (valid_q && bad_q) |-> (mode_q[1] && base_q == ChUpN))
  `RST_ASSERT(a_pass_through, (ctl_i.valid && !ctl_i.mode[1]) |=> (valid_q && base_q == $past(data_i)))
  `RST_ASSERT(a_strobe_follows_ctl, !ctl_i.valid |=> !valid_q)

endmodule
